[rtl/core/mcr_pkg.sv]
// shared types and constants for the maximum ratio cycle search block
package mcr_pkg;

   localparam int FRACTION_BITS = 16;
   localparam int RATIO_W       = 33;
   localparam int GAIN_W        = 64;
   localparam int VALUE_W       = 16;
   localparam int ID_W          = 10;
   localparam int PROD_W        = VALUE_W + RATIO_W;
   localparam int VCOUNT_W      = 11;
   localparam int STEPS_W       = 6;
   localparam int CMD_W         = 2;
   localparam int REQ_DATA_W    = 40;
   localparam int RSP_DATA_W    = 40;
   localparam int CSR_INDEX_W   = 1;

   localparam logic [RATIO_W-1:0] RATIO_TOP = RATIO_W'(64'd100000 << FRACTION_BITS);
   localparam logic [GAIN_W-1:0]  GAIN_MAX  = {1'b0, {(GAIN_W-1){1'b1}}};
   localparam logic [GAIN_W-1:0]  GAIN_MIN  = {1'b1, {(GAIN_W-1){1'b0}}};
   localparam logic [STEPS_W-1:0] STEPS_MAX = STEPS_W'(48);

   localparam logic [CMD_W-1:0] CMD_LOAD_VALUE = 2'd0;
   localparam logic [CMD_W-1:0] CMD_LOAD_EDGE  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_SOLVE      = 2'd2;
   localparam logic [CMD_W-1:0] CMD_RESERVED   = 2'd3;

   localparam logic [CSR_INDEX_W-1:0] CSR_VERTEX_COUNT = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SEARCH_STEPS = 1'b1;

   typedef enum logic [4:0] {
      S_CLEAR, S_IDLE, S_EDGE_WR, S_SOLVE, S_STEP, S_INIT, S_POP, S_POP_WAIT,
      S_U_WAIT, S_LINK, S_EDGE, S_WEIGHT, S_CAND, S_RELAX, S_PASS_YES, S_PASS_NO,
      S_RESULT
   } mcr_state_type;

   typedef enum logic [4:0] {
      OP_NONE, OP_LOAD_VALUE, OP_EDGE_READ, OP_EDGE_WRITE, OP_CLEAR_HEAD,
      OP_SOLVE_INIT, OP_STEP_INIT, OP_INIT_ENTRY, OP_POP_READ, OP_U_READ,
      OP_U_TAKE, OP_LINK_READ, OP_EDGE_SKIP, OP_EDGE_TAKE, OP_WEIGHT, OP_CAND,
      OP_RELAX, OP_PASS_YES, OP_PASS_NO, OP_RESULT
   } mcr_op_type;

   typedef struct packed {
      mcr_op_type op;
   } mcr_cmd_type;

   typedef struct packed {
      logic clear_last;
      logic init_last;
      logic queue_empty;
      logic link_zero;
      logic dest_out;
      logic improve;
      logic hop_full;
      logic steps_last;
      logic rsp_busy;
   } mcr_status_type;

endpackage

[rtl/core/max_ratio_cycle_search_top.sv]
// top level of the maximum ratio cycle search block
// Finds the best cycle ratio (vertex values over edge times) by bisection with
// a queue-based relaxation per step. A vertex value load writes the value table;
// an edge load reads the adjacency head, then links the edge in. A solve runs
// search_steps passes; each pass initialises the relaxation memories for n
// vertices, then takes vertices from the queue and examines their edges, all
// on single-port memories read through registers. After reset and after every
// solve all adjacency heads are cleared, during which no request is taken.
// Configuration writes are taken at any time.
module max_ratio_cycle_search_top #(
   parameter int MAX_VERTICES = 1024,
   parameter int MAX_EDGES    = 8192
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // vertex_id [9:0], edge_target [19:10], item_value [35:20]
   input  logic [mcr_pkg::REQ_DATA_W-1:0]        req_tdata,
   // cmd [1:0]
   input  logic [mcr_pkg::CMD_W-1:0]             req_tuser,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // best_ratio [32:0], edges_dropped [33]
   output logic [mcr_pkg::RSP_DATA_W-1:0]        rsp_tdata,
   input  logic                                  csr_we,
   input  logic [mcr_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  logic [mcr_pkg::VCOUNT_W-1:0]          csr_data
);

   mcr_pkg::mcr_cmd_type    cmd;
   mcr_pkg::mcr_status_type status;
   logic [mcr_pkg::RATIO_W-1:0] best_ratio;
   logic                        edges_dropped;

   mcr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_cmd    (req_tuser),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   mcr_datapath #(
      .MAX_VERTICES (MAX_VERTICES),
      .MAX_EDGES    (MAX_EDGES)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_vertex_id     (req_tdata[9:0]),
      .req_edge_target   (req_tdata[19:10]),
      .req_item_value    (req_tdata[35:20]),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .rsp_valid         (rsp_tvalid),
      .rsp_ready         (rsp_tready),
      .rsp_best_ratio    (best_ratio),
      .rsp_edges_dropped (edges_dropped)
   );

   assign rsp_tdata = {6'd0, edges_dropped, best_ratio};

endmodule

[rtl/core/mcr_ctrl.sv]
// sequencer for loads, bisection steps and queue-based relaxation
module mcr_ctrl (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   input  logic [mcr_pkg::CMD_W-1:0]    req_cmd,
   output logic                         req_tready,
   input  mcr_pkg::mcr_status_type      status,
   output mcr_pkg::mcr_cmd_type         cmd
);

   mcr_pkg::mcr_state_type state_ff, state_in;
   logic accept;

   assign accept = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mcr_pkg::S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         mcr_pkg::S_CLEAR: begin
            if (status.clear_last) state_in = mcr_pkg::S_IDLE;
         end
         mcr_pkg::S_IDLE: begin
            if (accept) begin
               if (req_cmd == mcr_pkg::CMD_LOAD_EDGE) state_in = mcr_pkg::S_EDGE_WR;
               else if (req_cmd == mcr_pkg::CMD_SOLVE) state_in = mcr_pkg::S_SOLVE;
            end
         end
         mcr_pkg::S_EDGE_WR:  state_in = mcr_pkg::S_IDLE;
         mcr_pkg::S_SOLVE:    state_in = mcr_pkg::S_STEP;
         mcr_pkg::S_STEP:     state_in = mcr_pkg::S_INIT;
         mcr_pkg::S_INIT: begin
            if (status.init_last) state_in = mcr_pkg::S_POP;
         end
         mcr_pkg::S_POP: begin
            state_in = status.queue_empty ? mcr_pkg::S_PASS_NO : mcr_pkg::S_POP_WAIT;
         end
         mcr_pkg::S_POP_WAIT: state_in = mcr_pkg::S_U_WAIT;
         mcr_pkg::S_U_WAIT:   state_in = mcr_pkg::S_LINK;
         mcr_pkg::S_LINK: begin
            state_in = status.link_zero ? mcr_pkg::S_POP : mcr_pkg::S_EDGE;
         end
         mcr_pkg::S_EDGE: begin
            state_in = status.dest_out ? mcr_pkg::S_LINK : mcr_pkg::S_WEIGHT;
         end
         mcr_pkg::S_WEIGHT:   state_in = mcr_pkg::S_CAND;
         mcr_pkg::S_CAND:     state_in = mcr_pkg::S_RELAX;
         mcr_pkg::S_RELAX: begin
            if (status.improve && status.hop_full) state_in = mcr_pkg::S_PASS_YES;
            else state_in = mcr_pkg::S_LINK;
         end
         mcr_pkg::S_PASS_YES, mcr_pkg::S_PASS_NO: begin
            state_in = status.steps_last ? mcr_pkg::S_RESULT : mcr_pkg::S_STEP;
         end
         mcr_pkg::S_RESULT: begin
            if (!status.rsp_busy) state_in = mcr_pkg::S_CLEAR;
         end
         default: state_in = mcr_pkg::S_CLEAR;
      endcase
   end

   always_comb begin
      cmd.op     = mcr_pkg::OP_NONE;
      req_tready = 1'b0;
      case (state_ff)
         mcr_pkg::S_CLEAR: cmd.op = mcr_pkg::OP_CLEAR_HEAD;
         mcr_pkg::S_IDLE: begin
            req_tready = 1'b1;
            if (accept) begin
               if (req_cmd == mcr_pkg::CMD_LOAD_VALUE) cmd.op = mcr_pkg::OP_LOAD_VALUE;
               else if (req_cmd == mcr_pkg::CMD_LOAD_EDGE) cmd.op = mcr_pkg::OP_EDGE_READ;
            end
         end
         mcr_pkg::S_EDGE_WR:  cmd.op = mcr_pkg::OP_EDGE_WRITE;
         mcr_pkg::S_SOLVE:    cmd.op = mcr_pkg::OP_SOLVE_INIT;
         mcr_pkg::S_STEP:     cmd.op = mcr_pkg::OP_STEP_INIT;
         mcr_pkg::S_INIT:     cmd.op = mcr_pkg::OP_INIT_ENTRY;
         mcr_pkg::S_POP: begin
            if (!status.queue_empty) cmd.op = mcr_pkg::OP_POP_READ;
         end
         mcr_pkg::S_POP_WAIT: cmd.op = mcr_pkg::OP_U_READ;
         mcr_pkg::S_U_WAIT:   cmd.op = mcr_pkg::OP_U_TAKE;
         mcr_pkg::S_LINK: begin
            if (!status.link_zero) cmd.op = mcr_pkg::OP_LINK_READ;
         end
         mcr_pkg::S_EDGE: begin
            cmd.op = status.dest_out ? mcr_pkg::OP_EDGE_SKIP : mcr_pkg::OP_EDGE_TAKE;
         end
         mcr_pkg::S_WEIGHT:   cmd.op = mcr_pkg::OP_WEIGHT;
         mcr_pkg::S_CAND:     cmd.op = mcr_pkg::OP_CAND;
         mcr_pkg::S_RELAX: begin
            if (status.improve && !status.hop_full) cmd.op = mcr_pkg::OP_RELAX;
         end
         mcr_pkg::S_PASS_YES: cmd.op = mcr_pkg::OP_PASS_YES;
         mcr_pkg::S_PASS_NO:  cmd.op = mcr_pkg::OP_PASS_NO;
         mcr_pkg::S_RESULT: begin
            if (!status.rsp_busy) cmd.op = mcr_pkg::OP_RESULT;
         end
         default: cmd.op = mcr_pkg::OP_NONE;
      endcase
   end

endmodule

[rtl/core/mcr_datapath.sv]
// graph tables, relaxation memories, bisection registers and result register
module mcr_datapath #(
   parameter int MAX_VERTICES = 1024,
   parameter int MAX_EDGES    = 8192
) (
   input  logic                               clock,
   input  logic                               reset,
   input  mcr_pkg::mcr_cmd_type               cmd,
   output mcr_pkg::mcr_status_type            status,
   input  logic [mcr_pkg::ID_W-1:0]           req_vertex_id,
   input  logic [mcr_pkg::ID_W-1:0]           req_edge_target,
   input  logic [mcr_pkg::VALUE_W-1:0]        req_item_value,
   input  logic                               csr_we,
   input  logic [mcr_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [mcr_pkg::VCOUNT_W-1:0]       csr_data,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [mcr_pkg::RATIO_W-1:0]        rsp_best_ratio,
   output logic                               rsp_edges_dropped
);

   localparam int VW  = $clog2(MAX_VERTICES);
   localparam int CW  = VW + 1;
   localparam int EIW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
   localparam int EW  = $clog2(MAX_EDGES + 1);
   localparam int GW  = mcr_pkg::GAIN_W;
   localparam int RW  = mcr_pkg::RATIO_W;

   // memories
   logic [mcr_pkg::VALUE_W-1:0] value_mem [MAX_VERTICES];
   logic [EW-1:0]               head_mem  [MAX_VERTICES];
   logic [mcr_pkg::ID_W-1:0]    dest_mem  [MAX_EDGES];
   logic [mcr_pkg::VALUE_W-1:0] time_mem  [MAX_EDGES];
   logic [EW-1:0]               next_mem  [MAX_EDGES];
   logic [GW-1:0]               gain_mem  [MAX_VERTICES];
   logic [CW-1:0]               hop_mem   [MAX_VERTICES];
   logic                        queued_mem[MAX_VERTICES];
   logic [VW-1:0]               queue_mem [MAX_VERTICES];

   logic [mcr_pkg::VALUE_W-1:0] value_rd_ff;
   logic [EW-1:0]               head_rd_ff;
   logic [mcr_pkg::ID_W-1:0]    dest_rd_ff;
   logic [mcr_pkg::VALUE_W-1:0] time_rd_ff;
   logic [EW-1:0]               next_rd_ff;
   logic [GW-1:0]               gain_rd_ff;
   logic [CW-1:0]               hop_rd_ff;
   logic                        queued_rd_ff;
   logic [VW-1:0]               q_rd_ff;

   // control and working registers
   logic [mcr_pkg::VCOUNT_W-1:0] vcount_ff;
   logic [mcr_pkg::STEPS_W-1:0]  steps_cfg_ff;
   logic [CW-1:0]                idx_ff, n_ff, qsize_ff;
   logic [VW-1:0]                qhead_ff, qtail_ff, u_ff, v_ff, esrc_ff;
   logic [mcr_pkg::STEPS_W-1:0]  steps_ff, step_ff;
   logic [RW-1:0]                low_ff, high_ff, mid_ff;
   logic [EW-1:0]                link_ff, total_ff;
   logic [GW-1:0]                gain_u_ff, w_ff, cand_ff;
   logic [CW-1:0]                hop_u_ff;
   logic [mcr_pkg::PROD_W-1:0]   prod_ff;
   logic [mcr_pkg::ID_W-1:0]     edst_ff;
   logic [mcr_pkg::VALUE_W-1:0]  eval_ff;
   logic                         eok_ff, overflow_ff;
   logic                         rsp_valid_ff;
   logic [RW-1:0]                rsp_ratio_ff;
   logic                         rsp_drop_ff;

   logic [31:0]   src_ext, dst_ext, dest_ext;
   logic [VW-1:0] src_idx, dest_idx, idx_lo;
   logic [EIW-1:0] link_idx, total_idx;
   logic          src_ok, dst_ok, edge_full, push;
   logic [GW-1:0] sum, sat_sum, val_shift;
   logic [CW-1:0] hop_next;
   logic [RW:0]   mid_sum;
   logic [VW-1:0] head_raddr, gain_raddr;

   assign src_ext   = 32'(req_vertex_id);
   assign dst_ext   = 32'(req_edge_target);
   assign dest_ext  = 32'(dest_rd_ff);
   assign src_idx   = src_ext[VW-1:0];
   assign dest_idx  = dest_ext[VW-1:0];
   assign idx_lo    = idx_ff[VW-1:0];
   assign src_ok    = src_ext < 32'(MAX_VERTICES);
   assign dst_ok    = dst_ext < 32'(MAX_VERTICES);
   assign link_idx  = EIW'(link_ff - EW'(1));
   assign total_idx = EIW'(total_ff);
   assign edge_full = 32'(total_ff) >= 32'(MAX_EDGES);
   assign hop_next  = CW'(hop_u_ff + CW'(1));
   assign push      = (cmd.op == mcr_pkg::OP_RELAX) && !queued_rd_ff;
   assign mid_sum   = {1'b0, low_ff} + {1'b0, high_ff};

   // saturating path gain add
   assign sum     = gain_u_ff + w_ff;
   assign sat_sum = ((gain_u_ff[GW-1] == w_ff[GW-1]) && (sum[GW-1] != gain_u_ff[GW-1]))
                    ? (gain_u_ff[GW-1] ? mcr_pkg::GAIN_MIN : mcr_pkg::GAIN_MAX) : sum;
   assign val_shift = GW'(value_rd_ff) << mcr_pkg::FRACTION_BITS;

   assign head_raddr = (cmd.op == mcr_pkg::OP_EDGE_READ) ? src_idx : q_rd_ff;
   assign gain_raddr = (cmd.op == mcr_pkg::OP_U_READ) ? q_rd_ff : dest_idx;

   always_ff @(posedge clock) begin
      if ((cmd.op == mcr_pkg::OP_LOAD_VALUE) && src_ok) value_mem[src_idx] <= req_item_value;
      if (cmd.op == mcr_pkg::OP_EDGE_TAKE) value_rd_ff <= value_mem[dest_idx];
   end

   always_ff @(posedge clock) begin
      if (cmd.op == mcr_pkg::OP_CLEAR_HEAD) begin
         head_mem[idx_lo] <= '0;
      end else if ((cmd.op == mcr_pkg::OP_EDGE_WRITE) && eok_ff && !edge_full) begin
         head_mem[esrc_ff] <= EW'(total_ff + EW'(1));
      end
      if ((cmd.op == mcr_pkg::OP_EDGE_READ) || (cmd.op == mcr_pkg::OP_U_READ)) begin
         head_rd_ff <= head_mem[head_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if ((cmd.op == mcr_pkg::OP_EDGE_WRITE) && eok_ff && !edge_full) begin
         dest_mem[total_idx] <= edst_ff;
         time_mem[total_idx] <= eval_ff;
         next_mem[total_idx] <= head_rd_ff;
      end
      if (cmd.op == mcr_pkg::OP_LINK_READ) begin
         dest_rd_ff <= dest_mem[link_idx];
         time_rd_ff <= time_mem[link_idx];
         next_rd_ff <= next_mem[link_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.op == mcr_pkg::OP_INIT_ENTRY) begin
         gain_mem[idx_lo] <= '0;
         hop_mem[idx_lo]  <= '0;
      end else if (cmd.op == mcr_pkg::OP_RELAX) begin
         gain_mem[v_ff] <= cand_ff;
         hop_mem[v_ff]  <= hop_next;
      end
      if ((cmd.op == mcr_pkg::OP_U_READ) || (cmd.op == mcr_pkg::OP_EDGE_TAKE)) begin
         gain_rd_ff <= gain_mem[gain_raddr];
         hop_rd_ff  <= hop_mem[gain_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.op == mcr_pkg::OP_INIT_ENTRY) queued_mem[idx_lo] <= 1'b1;
      else if (cmd.op == mcr_pkg::OP_U_READ) queued_mem[q_rd_ff] <= 1'b0;
      else if (push) queued_mem[v_ff] <= 1'b1;
      if (cmd.op == mcr_pkg::OP_EDGE_TAKE) queued_rd_ff <= queued_mem[dest_idx];
   end

   always_ff @(posedge clock) begin
      if (cmd.op == mcr_pkg::OP_INIT_ENTRY) queue_mem[idx_lo] <= idx_lo;
      else if (push) queue_mem[qtail_ff] <= v_ff;
      if (cmd.op == mcr_pkg::OP_POP_READ) q_rd_ff <= queue_mem[qhead_ff];
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         vcount_ff    <= mcr_pkg::VCOUNT_W'(2);
         steps_cfg_ff <= mcr_pkg::STEPS_W'(30);
         idx_ff       <= '0;
         qsize_ff     <= '0;
         qhead_ff     <= '0;
         qtail_ff     <= '0;
         total_ff     <= '0;
         overflow_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         low_ff       <= '0;
         high_ff      <= mcr_pkg::RATIO_TOP;
         step_ff      <= '0;
      end else begin
         if (csr_we && (csr_index == mcr_pkg::CSR_VERTEX_COUNT)) vcount_ff <= csr_data;
         if (csr_we && (csr_index == mcr_pkg::CSR_SEARCH_STEPS)) begin
            steps_cfg_ff <= csr_data[mcr_pkg::STEPS_W-1:0];
         end
         if (rsp_valid_ff && rsp_ready) rsp_valid_ff <= 1'b0;
         case (cmd.op)
            mcr_pkg::OP_CLEAR_HEAD, mcr_pkg::OP_INIT_ENTRY: begin
               idx_ff <= CW'(idx_ff + CW'(1));
               if (cmd.op == mcr_pkg::OP_INIT_ENTRY) begin
                  qsize_ff <= CW'(qsize_ff + CW'(1));
                  qtail_ff <= (qtail_ff == VW'(MAX_VERTICES - 1)) ? '0 : VW'(qtail_ff + VW'(1));
               end
            end
            mcr_pkg::OP_EDGE_WRITE: begin
               if (eok_ff) begin
                  if (edge_full) overflow_ff <= 1'b1;
                  else total_ff <= EW'(total_ff + EW'(1));
               end
            end
            mcr_pkg::OP_SOLVE_INIT: begin
               low_ff  <= '0;
               high_ff <= mcr_pkg::RATIO_TOP;
               step_ff <= '0;
            end
            mcr_pkg::OP_STEP_INIT: begin
               idx_ff   <= '0;
               qsize_ff <= '0;
               qhead_ff <= '0;
               qtail_ff <= '0;
            end
            mcr_pkg::OP_POP_READ: begin
               qsize_ff <= CW'(qsize_ff - CW'(1));
               qhead_ff <= (qhead_ff == VW'(MAX_VERTICES - 1)) ? '0 : VW'(qhead_ff + VW'(1));
            end
            mcr_pkg::OP_RELAX: begin
               if (push) begin
                  qsize_ff <= CW'(qsize_ff + CW'(1));
                  qtail_ff <= (qtail_ff == VW'(MAX_VERTICES - 1)) ? '0 : VW'(qtail_ff + VW'(1));
               end
            end
            mcr_pkg::OP_PASS_YES: begin
               low_ff  <= mid_ff;
               step_ff <= mcr_pkg::STEPS_W'(step_ff + 1'b1);
            end
            mcr_pkg::OP_PASS_NO: begin
               high_ff <= mid_ff;
               step_ff <= mcr_pkg::STEPS_W'(step_ff + 1'b1);
            end
            mcr_pkg::OP_RESULT: begin
               rsp_valid_ff <= 1'b1;
               idx_ff       <= '0;
               total_ff     <= '0;
               overflow_ff  <= 1'b0;
            end
            default: ;
         endcase
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      case (cmd.op)
         mcr_pkg::OP_EDGE_READ: begin
            esrc_ff <= src_idx;
            edst_ff <= req_edge_target;
            eval_ff <= req_item_value;
            eok_ff  <= src_ok && dst_ok;
         end
         mcr_pkg::OP_SOLVE_INIT: begin
            if (vcount_ff < mcr_pkg::VCOUNT_W'(2)) n_ff <= CW'(2);
            else if (32'(vcount_ff) > 32'(MAX_VERTICES)) n_ff <= CW'(MAX_VERTICES);
            else n_ff <= CW'(vcount_ff);
            if (steps_cfg_ff == '0) steps_ff <= mcr_pkg::STEPS_W'(1);
            else if (steps_cfg_ff > mcr_pkg::STEPS_MAX) steps_ff <= mcr_pkg::STEPS_MAX;
            else steps_ff <= steps_cfg_ff;
         end
         mcr_pkg::OP_STEP_INIT: mid_ff <= mid_sum[RW:1];
         mcr_pkg::OP_U_READ:    u_ff <= q_rd_ff;
         mcr_pkg::OP_U_TAKE: begin
            link_ff   <= head_rd_ff;
            gain_u_ff <= gain_rd_ff;
            hop_u_ff  <= hop_rd_ff;
         end
         mcr_pkg::OP_EDGE_SKIP: link_ff <= next_rd_ff;
         mcr_pkg::OP_EDGE_TAKE: begin
            link_ff <= next_rd_ff;
            v_ff    <= dest_idx;
            prod_ff <= mcr_pkg::PROD_W'(time_rd_ff) * mcr_pkg::PROD_W'(mid_ff);
         end
         mcr_pkg::OP_WEIGHT: w_ff <= val_shift - GW'(prod_ff);
         mcr_pkg::OP_CAND:   cand_ff <= sat_sum;
         mcr_pkg::OP_RELAX: begin
            // a self loop changes the gain of the vertex being expanded
            if (v_ff == u_ff) begin
               gain_u_ff <= cand_ff;
               hop_u_ff  <= hop_next;
            end
         end
         mcr_pkg::OP_RESULT: begin
            rsp_ratio_ff <= low_ff;
            rsp_drop_ff  <= overflow_ff;
         end
         default: ;
      endcase
   end

   assign status.clear_last  = idx_ff == CW'(MAX_VERTICES - 1);
   assign status.init_last   = idx_ff == CW'(n_ff - CW'(1));
   assign status.queue_empty = qsize_ff == '0;
   assign status.link_zero   = link_ff == '0;
   assign status.dest_out    = dest_ext >= 32'(n_ff);
   assign status.improve     = $signed(gain_rd_ff) < $signed(cand_ff);
   assign status.hop_full    = (32'(hop_u_ff) + 32'd1) >= 32'(n_ff);
   assign status.steps_last  = mcr_pkg::STEPS_W'(step_ff + 1'b1) == steps_ff;
   assign status.rsp_busy    = rsp_valid_ff;

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_best_ratio    = rsp_ratio_ff;
   assign rsp_edges_dropped = rsp_drop_ff;

   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      32'(qsize_ff) <= 32'(MAX_VERTICES))
      else $error("work queue holds more entries than vertices");
   a_bounds_order: assert property (@(posedge clock) disable iff (reset)
      low_ff <= high_ff)
      else $error("bisection bounds crossed");
   a_edge_bound: assert property (@(posedge clock) disable iff (reset)
      32'(total_ff) <= 32'(MAX_EDGES))
      else $error("edge count beyond capacity");
   a_result_slot: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == mcr_pkg::OP_RESULT) |-> !rsp_valid_ff)
      else $error("result overwritten before it was taken");

endmodule

[sim/cycle_ratio_checker.sv]
// checker for the maximum ratio cycle search block: predicts solve answers and compares them
`timescale 1ns / 100ps
module cycle_ratio_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   input  logic                                req_tready,
   input  logic [mcr_pkg::REQ_DATA_W-1:0]      req_tdata,
   input  logic [mcr_pkg::CMD_W-1:0]           req_tuser,
   input  logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   input  logic [mcr_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   input  logic                                csr_we,
   input  logic [mcr_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [mcr_pkg::VCOUNT_W-1:0]        csr_data,
   output int                                  fail_count,
   output int                                  answers_pending
);

   localparam int NV = 1024;
   localparam int NE = 8192;

   typedef struct {
      logic [mcr_pkg::RATIO_W-1:0] ratio;
      logic                        dropped;
   } answer_type;

   answer_type answer_q[$];

   logic [mcr_pkg::VALUE_W-1:0] vertex_value[NV];
   int unsigned                 adj_head[NV];
   int unsigned                 edge_dest[NE];
   int unsigned                 edge_next[NE];
   logic [mcr_pkg::VALUE_W-1:0] edge_time[NE];
   int unsigned                 edge_count;
   bit                          edge_overflow;
   int unsigned                 vertex_count_reg;
   int unsigned                 search_steps_reg;

   initial begin
      fail_count = 0;
      answers_pending = 0;
      foreach (vertex_value[i]) vertex_value[i] = '0;
      foreach (adj_head[i]) adj_head[i] = 0;
      edge_count = 0;
      edge_overflow = 0;
      vertex_count_reg = 2;
      search_steps_reg = 30;
   end

   function automatic longint gain_add(longint a, longint b);
      longint s;
      s = a + b;
      if (a > 0 && b > 0 && s < 0) return longint'(mcr_pkg::GAIN_MAX);
      if (a < 0 && b < 0 && s >= 0) return longint'(mcr_pkg::GAIN_MIN);
      return s;
   endfunction

   // queue-based longest path relaxation; true when a hop count reaches n
   function automatic bit gainful_cycle(int unsigned n, logic [63:0] trial);
      longint      gain[NV];
      int unsigned hops[NV];
      bit          queued[NV];
      int unsigned fifo[NV];
      int unsigned qh, qs, u, link, e, v;
      longint      w, cand;
      for (int i = 0; i < n; i++) begin
         gain[i] = 0;
         hops[i] = 0;
         queued[i] = 1;
         fifo[i] = i;
      end
      qh = 0;
      qs = n;
      while (qs > 0) begin
         u = fifo[qh];
         qh = (qh + 1) % NV;
         qs--;
         queued[u] = 0;
         link = adj_head[u];
         while (link != 0) begin
            e = link - 1;
            v = edge_dest[e];
            link = edge_next[e];
            if (v < n) begin
               w = longint'(64'(vertex_value[v]) << mcr_pkg::FRACTION_BITS)
                   - longint'(64'(edge_time[e]) * trial);
               cand = gain_add(gain[u], w);
               if (gain[v] < cand) begin
                  gain[v] = cand;
                  hops[v] = hops[u] + 1;
                  if (hops[v] >= n) return 1;
                  if (!queued[v]) begin
                     fifo[(qh + qs) % NV] = v;
                     qs++;
                     queued[v] = 1;
                  end
               end
            end
         end
      end
      return 0;
   endfunction

   function automatic answer_type best_ratio_of_graph();
      int unsigned n, steps;
      logic [63:0] lo, hi, mid;
      answer_type  a;
      n = vertex_count_reg;
      if (n < 2) n = 2;
      if (n > NV) n = NV;
      steps = search_steps_reg;
      if (steps < 1) steps = 1;
      if (steps > 48) steps = 48;
      lo = 0;
      hi = 64'(mcr_pkg::RATIO_TOP);
      for (int s = 0; s < steps; s++) begin
         mid = (lo + hi) >> 1;
         if (gainful_cycle(n, mid)) lo = mid;
         else hi = mid;
      end
      a.ratio = lo[mcr_pkg::RATIO_W-1:0];
      a.dropped = edge_overflow;
      foreach (adj_head[i]) adj_head[i] = 0;
      edge_count = 0;
      edge_overflow = 0;
      return a;
   endfunction

   always @(posedge clock) begin
      int unsigned src, dst;
      answer_type  want;
      if (!reset) begin
         if (csr_we) begin
            if (csr_index == mcr_pkg::CSR_VERTEX_COUNT) vertex_count_reg = csr_data;
            else search_steps_reg = csr_data[mcr_pkg::STEPS_W-1:0];
         end
         if (req_tvalid && req_tready) begin
            src = req_tdata[9:0];
            dst = req_tdata[19:10];
            case (req_tuser)
               mcr_pkg::CMD_LOAD_VALUE: vertex_value[src] = req_tdata[35:20];
               mcr_pkg::CMD_LOAD_EDGE: begin
                  if (edge_count >= NE) begin
                     edge_overflow = 1;
                  end else begin
                     edge_dest[edge_count] = dst;
                     edge_time[edge_count] = req_tdata[35:20];
                     edge_next[edge_count] = adj_head[src];
                     adj_head[src] = edge_count + 1;
                     edge_count++;
                  end
               end
               mcr_pkg::CMD_SOLVE: answer_q.push_back(best_ratio_of_graph());
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            if (answer_q.size() == 0) begin
               $error("unexpected result: tdata %h", rsp_tdata);
               fail_count++;
            end else begin
               want = answer_q.pop_front();
               if (rsp_tdata[32:0] !== want.ratio) begin
                  $error("best_ratio: expected %0d, got %0d", want.ratio, rsp_tdata[32:0]);
                  fail_count++;
               end
               if (rsp_tdata[33] !== want.dropped) begin
                  $error("edges_dropped: expected %0d, got %0d", want.dropped, rsp_tdata[33]);
                  fail_count++;
               end
            end
         end
         answers_pending = answer_q.size();
      end
   end

endmodule

[sim/testbench.sv]
// top of the testbench: clock, reset, graph stimulus, watchdog and verdict
`timescale 1ns / 100ps
module testbench;

   localparam int STALL_LIMIT = 5000000;
   localparam int SETTLE      = 1100;

   logic                                clock = 0;
   logic                                reset = 1;
   logic                                req_tvalid = 0;
   logic                                req_tready;
   logic [mcr_pkg::REQ_DATA_W-1:0]      req_tdata = '0;
   logic [mcr_pkg::CMD_W-1:0]           req_tuser = '0;
   logic                                rsp_tvalid;
   logic                                rsp_tready = 0;
   logic [mcr_pkg::RSP_DATA_W-1:0]      rsp_tdata;
   logic                                csr_we = 0;
   logic [mcr_pkg::CSR_INDEX_W-1:0]     csr_index = '0;
   logic [mcr_pkg::VCOUNT_W-1:0]        csr_data = '0;

   int          fail_count, answers_pending;
   int          send_idle = 13, recv_idle = 49;
   int          hold_left = 0;
   int          requests_sent = 0, solves_sent = 0, stall_cycles = 0;
   int unsigned graph_n = 2;
   bit          value_loaded[1024];
   bit          pressure_done = 0;

   always begin
      #2 clock = 1;
      #2 clock = 0;
   end

   max_ratio_cycle_search_top DUT (
      .clock, .reset, .req_tvalid, .req_tready, .req_tdata, .req_tuser,
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .csr_we, .csr_index, .csr_data
   );

   cycle_ratio_checker CHK (
      .clock, .reset, .req_tvalid, .req_tready, .req_tdata, .req_tuser,
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .csr_we, .csr_index, .csr_data,
      .fail_count, .answers_pending
   );

   // result side, with a long hold-off when asked
   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_tready <= 0;
         hold_left <= hold_left - 1;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle);
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) stall_cycles <= 0;
         else stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("testbench: errors");
            $finish;
         end
      end
   end

   task automatic send_req(input logic [mcr_pkg::CMD_W-1:0] op, input int unsigned id,
                           input int unsigned tgt, input int unsigned val);
      @(negedge clock);
      while ($urandom_range(99) < send_idle) begin
         req_tvalid <= 0;
         @(negedge clock);
      end
      req_tvalid <= 1;
      req_tuser <= op;
      req_tdata <= {4'b0, val[15:0], tgt[9:0], id[9:0]};
      do @(posedge clock); while (!req_tready);
      requests_sent++;
      if (op == mcr_pkg::CMD_LOAD_VALUE) value_loaded[id[9:0]] = 1;
      if (requests_sent < 533) begin
         send_idle = 13; recv_idle = 49;
      end else if (requests_sent < 1066) begin
         send_idle = 49; recv_idle = 13;
      end else begin
         send_idle = 0; recv_idle = 0;
      end
   endtask

   function automatic int unsigned pick_value();
      case ($urandom_range(3))
         0: return $urandom_range(1) ? 65535 : 0;
         1: return $urandom_range(15);
         default: return $urandom_range(65535);
      endcase
   endfunction

   function automatic int unsigned pick_vertex();
      if ($urandom_range(99) < 88) return $urandom_range(graph_n - 1);
      return $urandom_range(1023);
   endfunction

   // the block must never read a vertex value that was not loaded
   task automatic solve_graph();
      for (int v = 0; v < graph_n; v++)
         if (!value_loaded[v])
            send_req(mcr_pkg::CMD_LOAD_VALUE, v, $urandom_range(1023), pick_value());
      send_req(mcr_pkg::CMD_SOLVE, $urandom_range(1023), $urandom_range(1023),
               $urandom_range(65535));
      solves_sent++;
   endtask

   task automatic quiesce();
      @(negedge clock);
      req_tvalid <= 0;
      wait (answers_pending == 0);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic set_config(input int unsigned vc, input int unsigned st);
      quiesce();
      @(negedge clock);
      csr_we <= 1;
      csr_index <= mcr_pkg::CSR_VERTEX_COUNT;
      csr_data <= vc[mcr_pkg::VCOUNT_W-1:0];
      @(negedge clock);
      csr_index <= mcr_pkg::CSR_SEARCH_STEPS;
      csr_data <= mcr_pkg::VCOUNT_W'(($urandom_range(31) << 6) | (st & 63));
      @(negedge clock);
      csr_we <= 0;
      graph_n = (vc < 2) ? 2 : (vc > 1024) ? 1024 : vc;
   endtask

   task automatic random_graph();
      int unsigned edges, ring_len, first, prev, nxt;
      repeat ($urandom_range(3))
         send_req(mcr_pkg::CMD_LOAD_VALUE, pick_vertex(), $urandom_range(1023), pick_value());
      if ($urandom_range(99) < 35) begin
         ring_len = $urandom_range(2, (graph_n > 12) ? 12 : graph_n);
         first = $urandom_range(graph_n - 1);
         prev = first;
         for (int i = 1; i < ring_len; i++) begin
            nxt = $urandom_range(graph_n - 1);
            send_req(mcr_pkg::CMD_LOAD_EDGE, prev, nxt, pick_value());
            prev = nxt;
         end
         send_req(mcr_pkg::CMD_LOAD_EDGE, prev, first, pick_value());
      end
      edges = (graph_n > 64) ? $urandom_range(1, 64) : $urandom_range(1, 3 * graph_n);
      repeat (edges) begin
         send_req(mcr_pkg::CMD_LOAD_EDGE, pick_vertex(), pick_vertex(), pick_value());
         if ($urandom_range(99) < 3)
            send_req(mcr_pkg::CMD_RESERVED, $urandom_range(1023), $urandom_range(1023),
                     $urandom_range(65535));
      end
      // long result hold-off while requests keep coming
      if (!pressure_done && requests_sent > 200) begin
         pressure_done = 1;
         hold_left = 150000;
         solve_graph();
         repeat (4)
            send_req(mcr_pkg::CMD_LOAD_VALUE, pick_vertex(), $urandom_range(1023),
                     pick_value());
      end else begin
         solve_graph();
      end
   endtask

   initial begin
      int unsigned vc, st, phase;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // directed part with the reset settings of two vertices and thirty steps
      send_req(mcr_pkg::CMD_LOAD_VALUE, 0, 1023, 65535);
      send_req(mcr_pkg::CMD_LOAD_VALUE, 1, 0, 0);
      send_req(mcr_pkg::CMD_LOAD_EDGE, 0, 1, 0);
      send_req(mcr_pkg::CMD_LOAD_EDGE, 1, 0, 65535);
      send_req(mcr_pkg::CMD_RESERVED, 1023, 1023, 65535);
      send_req(mcr_pkg::CMD_LOAD_EDGE, 1023, 1023, 1);
      solve_graph();
      send_req(mcr_pkg::CMD_LOAD_EDGE, 0, 1, 0);
      send_req(mcr_pkg::CMD_LOAD_EDGE, 1, 0, 0);
      solve_graph();
      send_req(mcr_pkg::CMD_LOAD_EDGE, 0, 0, 65535);
      send_req(mcr_pkg::CMD_LOAD_EDGE, 1, 1000, 5);
      solve_graph();
      solve_graph();

      phase = 0;
      while (requests_sent < 1600) begin
         phase++;
         if (phase % 8 == 5) begin
            case ($urandom_range(2))
               0: vc = 1024;
               1: vc = 2047;
               default: vc = $urandom_range(1025, 2046);
            endcase
            st = $urandom_range(2);
         end else begin
            case ($urandom_range(5))
               0: vc = $urandom_range(1);
               1: vc = 2;
               default: vc = $urandom_range(3, 20);
            endcase
            case ($urandom_range(5))
               0: st = 0;
               1: st = 48;
               2: st = $urandom_range(49, 63);
               default: st = $urandom_range(1, 30);
            endcase
         end
         set_config(vc, st);
         repeat ($urandom_range(1, 4)) random_graph();
      end

      quiesce();
      $display("covered %0d requests and %0d solves, including saturated settings,",
               requests_sent, solves_sent);
      $display("unused command codes and a long result hold-off");
      if (answers_pending != 0) $error("%0d expected results never arrived", answers_pending);
      if (fail_count == 0 && answers_pending == 0) begin
         $display("testbench: clean");
      end else begin
         $display("testbench: errors");
      end
      $finish;
   end

endmodule
